[design/ffca_pkg.sv]
// Package for the first-fit contiguous allocator.
// Holds the word types, status codes, control struct and sizing defaults.
// No dependencies.
package ffca_pkg;

    localparam int MEM_UNITS_DEF = 256;
    localparam int MAX_PROCS_DEF = 32;
    localparam int UNIT_W        = 13;
    localparam int CFG_W         = 9;
    localparam logic [CFG_W-1:0] CFG_RST = 9'd256;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_IDS_GONE  = 3'd2,
        ST_ZERO_SIZE = 3'd3,
        ST_NOT_LIVE  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_ALLOC,
        FSM_REL
    } fsm_t;

    typedef struct packed {
        logic       kind;
        logic [8:0] request_size;
        logic [4:0] release_id;
    } in_t;

    typedef struct packed {
        status_t    status;
        logic [4:0] assigned_id;
        logic [7:0] block_start;
        logic [8:0] block_end;
        logic [5:0] live_processes;
    } out_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic              load;
        logic              shift;
        logic              mark_en;
        logic              mark_set;
        logic [UNIT_W-1:0] lo;
        logic [UNIT_W-1:0] hi;
    } ctl_t;

endpackage

[design/ffca_cell.sv]
// One allocation unit: occupancy bit plus the scan token stage.
// Depends on ffca_pkg.
module ffca_cell #(
    parameter int IDX = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ffca_pkg::ctl_t ctl,
    input  logic          tok_in,
    output logic          tok_out,
    output logic          probe
);

    localparam logic [ffca_pkg::UNIT_W-1:0] POS = ffca_pkg::UNIT_W'(IDX);
    localparam logic IS_HEAD = (IDX == 0);

    logic occ_reg, occ_next;
    logic tok_reg, tok_next;

    always_comb
    begin
        occ_next = occ_reg;
        if (ctl.mark_en && (POS >= ctl.lo) && (POS < ctl.hi))
        begin
            occ_next = ctl.mark_set;
        end
        if (ctl.load)
        begin
            tok_next = IS_HEAD;
        end
        else
        begin
            tok_next = ctl.shift & tok_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
            tok_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;
    assign probe   = tok_reg & occ_reg;

endmodule

[design/first_fit_contiguous_allocator.sv]
// First-fit contiguous allocator: sequencer, range memory and the row of unit cells.
// Depends on ffca_pkg and ffca_cell.
//
// A command word is taken when start is high and busy is low. Zero-size, ids-exhausted
// and empty-map allocates, and releases of ids that are not live, answer in the next
// cycle without raising busy. A release of a live id passes through FSM_REL to its result.
// An allocate walks a token through the cell row one unit per cycle from unit 0; it
// stops at the end of the first fitting run and marks it in FSM_ALLOC, or reports no
// space once lim units are scanned, lim being memory_units capped at MEM_UNITS. The result
// word is on result for exactly one cycle, marked by done, and must be taken then.
module first_fit_contiguous_allocator #(
    parameter int MEM_UNITS = ffca_pkg::MEM_UNITS_DEF,
    parameter int MAX_PROCS = ffca_pkg::MAX_PROCS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  ffca_pkg::in_t              cmd,
    output logic                       done,
    output ffca_pkg::out_t             result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ffca_pkg::CFG_W-1:0] cfg_data
);

    localparam int AW = $clog2(MEM_UNITS);
    localparam int JW = AW + 1;
    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int NW = $clog2(MAX_PROCS + 1);
    localparam int LW = $clog2(MAX_PROCS + 1);
    localparam int TW = AW + JW;

    ffca_pkg::fsm_t state_reg, state_next;
    logic [ffca_pkg::CFG_W-1:0] units_reg, units_next;
    logic [8:0]           req_reg, req_next;
    logic [IW-1:0]        rid_reg, rid_next;
    logic [JW-1:0]        j_reg, j_next;
    logic [JW-1:0]        run_reg, run_next;
    logic [JW-1:0]        lim_reg, lim_next;
    logic [AW-1:0]        lo_reg, lo_next;
    logic [JW-1:0]        hi_reg, hi_next;
    logic [NW-1:0]        next_id_reg, next_id_next;
    logic [LW-1:0]        live_cnt_reg, live_cnt_next;
    logic [MAX_PROCS-1:0] live_reg, live_next;
    logic                 done_reg, done_next;
    ffca_pkg::out_t       result_reg, result_next;

    logic [TW-1:0] tab_mem [MAX_PROCS];
    logic [TW-1:0] tab_rd_reg;
    logic          tab_we;
    logic [IW-1:0] tab_wa;
    logic [TW-1:0] tab_wd;

    ffca_pkg::ctl_t       ctl;
    logic [MEM_UNITS-1:0] tok_vec;
    logic [MEM_UNITS-1:0] probe_vec;
    logic                 hit;

    logic          accept;
    logic [31:0]   lim_wide;
    logic [JW-1:0] j_inc;
    logic [JW-1:0] run_inc;
    logic [IW-1:0] cmd_idx;
    logic [AW-1:0] rd_lo;
    logic [JW-1:0] rd_hi;

    genvar g;
    generate
        for (g = 0; g < MEM_UNITS; g++)
        begin : g_cell
            logic tin;
            if (g == 0)
            begin : g_head
                assign tin = 1'b0;
            end
            else
            begin : g_body
                assign tin = tok_vec[g-1];
            end
            ffca_cell #(.IDX(g)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .tok_in  (tin),
                .tok_out (tok_vec[g]),
                .probe   (probe_vec[g])
            );
        end
    endgenerate

    assign hit       = |probe_vec;
    assign busy      = (state_reg != ffca_pkg::FSM_IDLE);
    assign cfg_ready = (state_reg == ffca_pkg::FSM_IDLE);
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign result    = result_reg;

    assign lim_wide = (32'(units_reg) > MEM_UNITS) ? MEM_UNITS : 32'(units_reg);
    assign j_inc    = j_reg + JW'(1);
    assign run_inc  = run_reg + JW'(1);
    assign cmd_idx  = IW'(cmd.release_id);
    assign rd_lo    = tab_rd_reg[TW-1:JW];
    assign rd_hi    = tab_rd_reg[JW-1:0];

    always_comb
    begin
        state_next    = state_reg;
        units_next    = units_reg;
        req_next      = req_reg;
        rid_next      = rid_reg;
        j_next        = j_reg;
        run_next      = run_reg;
        lim_next      = lim_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        next_id_next  = next_id_reg;
        live_cnt_next = live_cnt_reg;
        live_next     = live_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        tab_we        = 1'b0;
        tab_wa        = IW'(next_id_reg);
        tab_wd        = {lo_reg, hi_reg};
        ctl           = '0;

        if (cfg_valid && cfg_ready)
        begin
            units_next = cfg_data;
        end

        case (state_reg)
            ffca_pkg::FSM_IDLE:
            begin
                if (accept)
                begin
                    req_next = cmd.request_size;
                    rid_next = cmd_idx;
                    result_next = '0;
                    result_next.live_processes = 6'(live_cnt_reg);
                    if (cmd.kind == ffca_pkg::KIND_ALLOC)
                    begin
                        if (cmd.request_size == 9'd0)
                        begin
                            result_next.status = ffca_pkg::ST_ZERO_SIZE;
                            done_next = 1'b1;
                        end
                        else if (32'(next_id_reg) >= MAX_PROCS)
                        begin
                            result_next.status = ffca_pkg::ST_IDS_GONE;
                            done_next = 1'b1;
                        end
                        else if (lim_wide == 32'd0)
                        begin
                            result_next.status = ffca_pkg::ST_NO_SPACE;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            ctl.load   = 1'b1;
                            j_next     = '0;
                            run_next   = '0;
                            lim_next   = JW'(lim_wide);
                            state_next = ffca_pkg::FSM_SCAN;
                        end
                    end
                    else
                    begin
                        if ((32'(cmd.release_id) >= MAX_PROCS) || !live_reg[cmd_idx])
                        begin
                            result_next.status = ffca_pkg::ST_NOT_LIVE;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            state_next = ffca_pkg::FSM_REL;
                        end
                    end
                end
            end

            ffca_pkg::FSM_SCAN:
            begin
                ctl.shift = 1'b1;
                j_next    = j_inc;
                run_next  = hit ? '0 : run_inc;
                if (!hit && (32'(run_inc) == 32'(req_reg)))
                begin
                    ctl.shift  = 1'b0;
                    lo_next    = AW'(j_inc - run_inc);
                    hi_next    = j_inc;
                    state_next = ffca_pkg::FSM_ALLOC;
                end
                else if (j_inc == lim_reg)
                begin
                    ctl.shift          = 1'b0;
                    result_next.status = ffca_pkg::ST_NO_SPACE;
                    done_next          = 1'b1;
                    state_next         = ffca_pkg::FSM_IDLE;
                end
            end

            ffca_pkg::FSM_ALLOC:
            begin
                ctl.mark_en  = 1'b1;
                ctl.mark_set = 1'b1;
                ctl.lo       = ffca_pkg::UNIT_W'(lo_reg);
                ctl.hi       = ffca_pkg::UNIT_W'(hi_reg);
                tab_we       = 1'b1;
                live_next[IW'(next_id_reg)] = 1'b1;
                next_id_next  = next_id_reg + NW'(1);
                live_cnt_next = live_cnt_reg + LW'(1);
                result_next.status         = ffca_pkg::ST_OK;
                result_next.assigned_id    = 5'(next_id_reg);
                result_next.block_start    = 8'(lo_reg);
                result_next.block_end      = 9'(hi_reg);
                result_next.live_processes = 6'(live_cnt_reg + LW'(1));
                done_next  = 1'b1;
                state_next = ffca_pkg::FSM_IDLE;
            end

            ffca_pkg::FSM_REL:
            begin
                ctl.mark_en  = 1'b1;
                ctl.mark_set = 1'b0;
                ctl.lo       = ffca_pkg::UNIT_W'(rd_lo);
                ctl.hi       = ffca_pkg::UNIT_W'(rd_hi);
                live_next[rid_reg] = 1'b0;
                live_cnt_next = live_cnt_reg - LW'(1);
                result_next.status         = ffca_pkg::ST_OK;
                result_next.assigned_id    = 5'(rid_reg);
                result_next.block_start    = 8'(rd_lo);
                result_next.block_end      = 9'(rd_hi);
                result_next.live_processes = 6'(live_cnt_reg - LW'(1));
                done_next  = 1'b1;
                state_next = ffca_pkg::FSM_IDLE;
            end

            default:
            begin
                state_next = ffca_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ffca_pkg::FSM_IDLE;
            units_reg    <= ffca_pkg::CFG_RST;
            next_id_reg  <= '0;
            live_cnt_reg <= '0;
            live_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            units_reg    <= units_next;
            next_id_reg  <= next_id_next;
            live_cnt_reg <= live_cnt_next;
            live_reg     <= live_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        rid_reg    <= rid_next;
        j_reg      <= j_next;
        run_reg    <= run_next;
        lim_reg    <= lim_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        result_reg <= result_next;
    end

    // range memory: written on allocate, read at the command's id
    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[tab_wa] <= tab_wd;
        end
        tab_rd_reg <= tab_mem[cmd_idx];
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ffca_pkg::FSM_IDLE))
        else $error("result strobe while busy");

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffca_pkg::FSM_SCAN) |-> $onehot(tok_vec))
        else $error("scan token lost or duplicated");

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(live_cnt_reg) <= 32'(next_id_reg))
        else $error("live count exceeds ids handed out");

    a_live_bits: assert property (@(posedge clk) disable iff (!rst_n)
        32'($countones(live_reg)) == 32'(live_cnt_reg))
        else $error("live count disagrees with live entries");

endmodule
